[src/wsah_pkg.sv]
`timescale 1ns / 1ps

package wsah_pkg;

	typedef enum logic [1:0] {
		REQ_LOAD_POINT = 2'd0,
		REQ_LOAD_HALO  = 2'd1,
		REQ_STEP       = 2'd2,
		REQ_NONE       = 2'd3
	} req_t;

	typedef enum logic [0:0] {
		CFG_CFL   = 1'b0,
		CFG_DELAY = 1'b1
	} cfg_idx_t;

	localparam int CFL_W   = 17;
	localparam int DELAY_W = 4;
	localparam int IDX_W   = 6;
	localparam logic [CFL_W-1:0]   CFL_RESET   = 17'd164;
	localparam logic [DELAY_W-1:0] DELAY_RESET = 4'd5;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_RUN  = 2'd1,
		ST_DONE = 2'd2
	} back_state_t;

	// decoded word that the front hands to the back
	typedef struct packed {
		logic       do_step;
		logic       wr_point;
		logic       wr_halo;
		logic       halo_side;
		logic [1:0] halo_slot;
		logic [IDX_W-1:0] point_index;
	} cmd_t;

endpackage

[src/wsah_if.sv]
`timescale 1ns / 1ps

interface wsah_in_if #(parameter int VALUE_WIDTH = 32);
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [5:0] point_index;
	logic signed [VALUE_WIDTH-1:0] prev_value;
	logic signed [VALUE_WIDTH-1:0] curr_value;
	logic       halo_side;
	logic [1:0] halo_slot;
	logic signed [VALUE_WIDTH-1:0] halo_value;
	modport source (output valid, req_type, point_index, prev_value, curr_value,
		halo_side, halo_slot, halo_value, input ready);
	modport sink (input valid, req_type, point_index, prev_value, curr_value,
		halo_side, halo_slot, halo_value, output ready);
endinterface

interface wsah_out_if #(parameter int VALUE_WIDTH = 32);
	logic       valid;
	logic       ready;
	logic [5:0] out_index;
	logic signed [VALUE_WIDTH-1:0] new_value;
	logic       last_point;
	modport source (output valid, out_index, new_value, last_point, input ready);
	modport sink (input valid, out_index, new_value, last_point, output ready);
endinterface

interface wsah_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [16:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[src/wsah_front.sv]
`timescale 1ns / 1ps

module wsah_front import wsah_pkg::*; #(
	parameter int POINTS = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	wsah_in_if.sink in_ch,
	output logic q_valid,
	input  logic q_pop,
	output cmd_t q_cmd,
	output logic [VALUE_WIDTH-1:0] q_prev,
	output logic [VALUE_WIDTH-1:0] q_curr,
	output logic [VALUE_WIDTH-1:0] q_halo
);
	localparam int D = 2;

	cmd_t cmd_q [D];
	logic [VALUE_WIDTH-1:0] prev_q [D];
	logic [VALUE_WIDTH-1:0] curr_q [D];
	logic [VALUE_WIDTH-1:0] halo_q [D];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	cmd_t cmd_d;
	logic push;

	// classify the incoming word
	always_comb begin
		cmd_d = '0;
		cmd_d.halo_side = in_ch.halo_side;
		cmd_d.halo_slot = in_ch.halo_slot;
		cmd_d.point_index = in_ch.point_index;
		unique case (req_t'(in_ch.req_type))
			REQ_LOAD_POINT: cmd_d.wr_point = ({26'd0, in_ch.point_index} < POINTS);
			REQ_LOAD_HALO:  cmd_d.wr_halo = 1'b1;
			REQ_STEP:       cmd_d.do_step = 1'b1;
			default:        cmd_d = cmd_d;
		endcase
	end

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wp_q]  <= cmd_d;
			prev_q[wp_q] <= in_ch.prev_value;
			curr_q[wp_q] <= in_ch.curr_value;
			halo_q[wp_q] <= in_ch.halo_value;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd = cmd_q[rp_q];
	assign q_prev = prev_q[rp_q];
	assign q_curr = curr_q[rp_q];
	assign q_halo = halo_q[rp_q];

endmodule

[src/wsah_back.sv]
`timescale 1ns / 1ps

module wsah_back import wsah_pkg::*; #(
	parameter int POINTS = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_pop,
	input  cmd_t q_cmd,
	input  logic [VALUE_WIDTH-1:0] q_prev,
	input  logic [VALUE_WIDTH-1:0] q_curr,
	input  logic [VALUE_WIDTH-1:0] q_halo,
	input  logic [CFL_W-1:0] cfl,
	input  logic [DELAY_W-1:0] delay,
	wsah_out_if.source out_ch
);
	localparam int PW = (POINTS > 1) ? $clog2(POINTS) : 1;
	localparam int W = VALUE_WIDTH;
	localparam int UW = W + 4;
	localparam int PRW = UW + CFL_W + 1;
	localparam logic [PW-1:0] LAST = PW'(POINTS - 1);
	localparam logic signed [PRW-1:0] SAT_HI = $signed({{(PRW-W+1){1'b0}}, {(W-1){1'b1}}});
	localparam logic signed [PRW-1:0] SAT_LO = $signed({{(PRW-W+1){1'b1}}, {(W-1){1'b0}}});

	logic [W-1:0] prev_mem [POINTS];
	logic [W-1:0] curr_mem [POINTS];
	logic [W-1:0] nxt_mem [POINTS];
	logic signed [W-1:0] lh_q [4];
	logic signed [W-1:0] rh_q [4];
	logic [DELAY_W-1:0] phase_q;
	back_state_t st_q, st_d;
	logic [PW-1:0] idx_q;
	logic [PW-1:0] oidx_q;
	logic sweep_q;
	logic signed [UW-1:0] uxx_s1;
	logic signed [W+1:0] base_s1;
	logic [PW-1:0] idx_s1;
	logic v_s1;
	logic signed [PRW-1:0] prod_s2;
	logic signed [W+1:0] base_s2;
	logic [PW-1:0] idx_s2;
	logic v_s2;
	logic [PW-1:0] cnt_q;
	logic ovalid_q;
	logic [PW-1:0] oi_q;
	logic [W-1:0] oval_q;
	logic signed [UW-1:0] uxx_d;
	logic signed [W-1:0] c0, cm, cp, pv;
	logic signed [PRW-1:0] sum_w;
	logic signed [W-1:0] sat_w;
	logic out_free, asyn;
	logic load_out;

	assign asyn = (phase_q != '0);
	assign out_free = !ovalid_q || out_ch.ready;

	// compute operand fetch for the current point
	always_comb begin
		c0 = curr_mem[idx_q];
		pv = prev_mem[idx_q];
		cm = (idx_q == '0) ? lh_q[3] : curr_mem[idx_q - PW'(1)];
		cp = (idx_q == LAST) ? rh_q[0] : curr_mem[idx_q + PW'(1)];
		if (asyn && idx_q == '0)
			uxx_d = UW'(lh_q[0]) - 3 * UW'(lh_q[1]) + 3 * UW'(lh_q[2]) - UW'(lh_q[3])
				+ UW'($signed(curr_mem[0])) - 2 * UW'($signed(curr_mem[1]))
				+ UW'($signed(curr_mem[2]));
		else if (asyn && idx_q == LAST)
			uxx_d = -UW'(rh_q[0]) + 3 * UW'(rh_q[1]) - 3 * UW'(rh_q[2]) + UW'(rh_q[3])
				+ UW'($signed(curr_mem[LAST])) - 2 * UW'($signed(curr_mem[LAST - PW'(1)]))
				+ UW'($signed(curr_mem[LAST - PW'(2)]));
		else
			uxx_d = UW'(cm) - 2 * UW'(c0) + UW'(cp);
	end

	// sequencer
	always_comb begin
		st_d = st_q;
		q_pop = 1'b0;
		unique case (st_q)
			ST_IDLE: if (q_valid) begin
				if (q_cmd.do_step) st_d = ST_RUN;
				else q_pop = 1'b1;
			end
			ST_RUN: if (idx_q == LAST) st_d = ST_DONE;
			ST_DONE: if (sweep_q && oidx_q == LAST && out_free && v_s2 == 1'b0
				&& v_s1 == 1'b0) begin
				q_pop = 1'b1;
				st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// load writes and level shift
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && q_valid && q_cmd.wr_point) begin
			prev_mem[q_cmd.point_index[PW-1:0]] <= q_prev;
			curr_mem[q_cmd.point_index[PW-1:0]] <= q_curr;
		end
		if (v_s2) nxt_mem[idx_s2] <= sat_w;
		if (st_q == ST_DONE && q_pop) begin
			for (int i = 0; i < POINTS; i++) begin
				prev_mem[i] <= curr_mem[i];
				curr_mem[i] <= nxt_mem[i];
			end
		end
	end

	// stage 1: stencil; stage 2: scale by cfl
	always_ff @(posedge clk) begin
		uxx_s1 <= uxx_d;
		base_s1 <= 2 * (W+2)'(c0) - (W+2)'(pv);
		idx_s1 <= idx_q;
		prod_s2 <= $signed({1'b0, cfl}) * PRW'(uxx_s1);
		base_s2 <= base_s1;
		idx_s2 <= idx_s1;
	end

	// round, add and saturate
	always_comb begin
		sum_w = PRW'(base_s2) + ((prod_s2 + PRW'(32768)) >>> 16);
		if (sum_w > SAT_HI)
			sat_w = {1'b0, {(W-1){1'b1}}};
		else if (sum_w < SAT_LO)
			sat_w = {1'b1, {(W-1){1'b0}}};
		else
			sat_w = W'(sum_w);
	end

	// next result word goes into the output register
	assign load_out = sweep_q && out_free && !(oidx_q == LAST && ovalid_q && cnt_q == LAST)
		&& !(st_q == ST_DONE && q_pop) && !(cnt_q == LAST && oi_q == LAST && ovalid_q);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			idx_q <= '0;
			oidx_q <= '0;
			sweep_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			cnt_q <= '0;
			ovalid_q <= 1'b0;
			oi_q <= '0;
			oval_q <= '0;
			phase_q <= '0;
			for (int i = 0; i < 4; i++) begin
				lh_q[i] <= '0;
				rh_q[i] <= '0;
			end
		end else begin
			st_q <= st_d;
			v_s1 <= (st_q == ST_RUN);
			v_s2 <= v_s1;
			if (st_q == ST_RUN) idx_q <= (idx_q == LAST) ? '0 : idx_q + PW'(1);
			if (st_q == ST_IDLE && q_valid && q_cmd.wr_halo) begin
				if (q_cmd.halo_side) rh_q[q_cmd.halo_slot] <= q_halo;
				else lh_q[q_cmd.halo_slot] <= q_halo;
			end
			if (v_s2 && idx_s2 == LAST) sweep_q <= 1'b1;
			// results go out after all values are written
			if (load_out) begin
				ovalid_q <= 1'b1;
				oi_q <= cnt_q;
				oval_q <= nxt_mem[cnt_q];
				oidx_q <= cnt_q;
				cnt_q <= (cnt_q == LAST) ? cnt_q : cnt_q + PW'(1);
			end else if (out_ch.valid && out_ch.ready) begin
				ovalid_q <= 1'b0;
			end
			if (st_q == ST_DONE && q_pop) begin
				sweep_q <= 1'b0;
				cnt_q <= '0;
				oidx_q <= '0;
				phase_q <= ({1'b0, phase_q} + 5'd1 >= {1'b0, (delay == '0) ? 4'd1 : delay})
					? '0 : phase_q + 4'd1;
			end
		end
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.out_index = 6'(oi_q);
	assign out_ch.new_value = oval_q;
	assign out_ch.last_point = (oi_q == LAST);

endmodule

[src/wave_stencil_async_halo_step.sv]
`timescale 1ns / 1ps

// Wave-grid partition stepper. Load words write a grid point or a halo word;
// a step word runs the stencil over all POINTS points, one point a cycle
// through a two-stage multiply pipeline, then emits POINTS results in index
// order (last_point on the final one).
// A two-entry queue lets the input side take one more word during a step.
module wave_stencil_async_halo_step import wsah_pkg::*; #(
	parameter int POINTS = 16,
	parameter int VALUE_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	wsah_in_if.sink in_ch,
	wsah_out_if.source out_ch,
	wsah_cfg_if.sink cfg
);
	logic [CFL_W-1:0] cfl_q;
	logic [DELAY_W-1:0] delay_q;
	logic q_valid, q_pop;
	cmd_t q_cmd;
	logic [VALUE_WIDTH-1:0] q_prev, q_curr, q_halo;

	// config registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfl_q <= CFL_RESET;
			delay_q <= DELAY_RESET;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_CFL:   cfl_q <= cfg.data;
				CFG_DELAY: delay_q <= cfg.data[DELAY_W-1:0];
				default:   cfl_q <= cfl_q;
			endcase
		end
	end

	wsah_front #(.POINTS(POINTS), .VALUE_WIDTH(VALUE_WIDTH)) u_front (
		.clk, .arst_n, .in_ch,
		.q_valid, .q_pop, .q_cmd, .q_prev, .q_curr, .q_halo
	);

	wsah_back #(.POINTS(POINTS), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_cmd, .q_prev, .q_curr, .q_halo,
		.cfl(cfl_q), .delay(delay_q), .out_ch
	);

endmodule
